// ===== src/rfp_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rfp_pkg: shared types and constants of the radar frame parser
// Status codes, register indexes, queue sizing and the structs passed
// between the front end, the event queue and the back end.
// ============================================================================
package rfp_pkg;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_CSUM = 2'd1;
    localparam logic [1:0] ST_TAIL = 2'd2;

    // Configuration register indexes
    localparam int          CFG_IW       = 3;
    localparam int          CFG_DW       = 16;
    localparam logic [2:0]  CFG_HEADER   = 3'd0;
    localparam logic [2:0]  CFG_TAIL     = 3'd1;
    localparam logic [2:0]  CFG_PRESENCE = 3'd2;
    localparam logic [2:0]  CFG_MOTION   = 3'd3;
    localparam logic [2:0]  CFG_REGION   = 3'd4;
    localparam logic [2:0]  CFG_LIMIT    = 3'd5;

    // Register reset values
    localparam logic [7:0]  RST_HEADER   = 8'd170;
    localparam logic [7:0]  RST_TAIL     = 8'd85;
    localparam logic [7:0]  RST_PRESENCE = 8'd1;
    localparam logic [7:0]  RST_MOTION   = 8'd2;
    localparam logic [7:0]  RST_REGION   = 8'd3;
    localparam logic [15:0] RST_LIMIT    = 16'd250;

    // Event queue sizing (depth must be a power of two)
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [7:0]  header_value;
        logic [7:0]  tail_value;
        logic [7:0]  code_presence;
        logic [7:0]  code_motion;
        logic [7:0]  code_region;
        logic [15:0] length_limit;
    } t_cfg;

    // One frame-end event: status, code, the first four data bytes and a length-at-least-four flag
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  code;
        logic [7:0]  head0;
        logic [7:0]  head1;
        logic [7:0]  head2;
        logic [7:0]  head3;
        logic        len_ge4;
    } t_event;

endpackage

// ===== src/rfp_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rfp_front: byte-level frame tracker
// Hunts for the header, reads length and code, captures the first data bytes,
// keeps the running checksum and pushes one event per finished frame.
// ============================================================================
module rfp_front
    import rfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    output logic       o_push,
    output t_event     o_event
);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_LEN_LO = 3'd1;
    localparam logic [2:0] PH_LEN_HI = 3'd2;
    localparam logic [2:0] PH_CODE   = 3'd3;
    localparam logic [2:0] PH_DATA   = 3'd4;
    localparam logic [2:0] PH_CSUM   = 3'd5;
    localparam logic [2:0] PH_TAIL   = 3'd6;

    logic [2:0]  r_phase, n_phase;
    logic [15:0] r_len,   n_len;
    logic [15:0] r_count, n_count;
    logic [7:0]  r_code,  n_code;
    logic [7:0]  r_sum,   n_sum;
    logic [7:0]  r_head [4];
    logic [7:0]  n_head [4];
    logic [16:0] w_count_inc;
    logic [15:0] w_len_full;

    assign w_count_inc = {1'b0, r_count} + 17'd1;
    assign w_len_full  = {i_byte, r_len[7:0]};

    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_count = r_count;
        n_code  = r_code;
        n_sum   = r_sum;
        n_head  = r_head;
        o_push  = 1'b0;
        o_event.status  = ST_OK;
        o_event.code    = r_code;
        o_event.head0   = r_head[0];
        o_event.head1   = r_head[1];
        o_event.head2   = r_head[2];
        o_event.head3   = r_head[3];
        o_event.len_ge4 = (r_len >= 16'd4);
        if (i_accept) begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_byte == i_cfg.header_value) begin
                        for (int k = 0; k < 4; k++) n_head[k] = 8'd0;
                        n_sum   = i_byte;
                        n_len   = 16'd0;
                        n_count = 16'd0;
                        n_phase = PH_LEN_LO;
                    end
                end
                PH_LEN_LO: begin
                    n_sum   = r_sum + i_byte;
                    n_len   = {8'd0, i_byte};
                    n_phase = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_sum   = r_sum + i_byte;
                    n_len   = w_len_full;
                    n_phase = (w_len_full > i_cfg.length_limit) ? PH_IDLE : PH_CODE;
                end
                PH_CODE: begin
                    n_sum   = r_sum + i_byte;
                    n_code  = i_byte;
                    n_count = 16'd0;
                    n_phase = (r_len == 16'd0) ? PH_CSUM : PH_DATA;
                end
                PH_DATA: begin
                    n_sum = r_sum + i_byte;
                    if (r_count < 16'd4) n_head[r_count[1:0]] = i_byte;
                    n_count = w_count_inc[15:0];
                    if (w_count_inc >= {1'b0, r_len}) n_phase = PH_CSUM;
                end
                PH_CSUM: begin
                    if (i_byte == r_sum) begin
                        n_phase = PH_TAIL;
                    end else begin
                        n_phase        = PH_IDLE;
                        o_push         = 1'b1;
                        o_event.status = ST_CSUM;
                    end
                end
                PH_TAIL: begin
                    n_phase        = PH_IDLE;
                    o_push         = 1'b1;
                    o_event.status = (i_byte == i_cfg.tail_value) ? ST_OK : ST_TAIL;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_len   <= 16'd0;
            r_count <= 16'd0;
            r_code  <= 8'd0;
            r_sum   <= 8'd0;
            for (int k = 0; k < 4; k++) r_head[k] <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_count <= n_count;
            r_code  <= n_code;
            r_sum   <= n_sum;
            r_head  <= n_head;
        end
    end

endmodule

// ===== src/rfp_queue.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rfp_queue: short event queue
// Decouples the byte front end from the result back end.
// ============================================================================
module rfp_queue
    import rfp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_event i_event,
    input  logic   i_pop,
    output t_event o_event,
    output logic   o_full,
    output logic   o_empty
);

    t_event            r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr;
    logic [Q_CW-1:0]   r_count;

    assign o_full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_event = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_event;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("event queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("event queue underflow");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CW'(Q_DEPTH))
        else $error("event queue count out of range");

endmodule

// ===== src/rfp_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rfp_back: frame result stage
// Pops frame events, updates the latest sensor values on good frames and
// holds each result in an output register until it is taken.
// ============================================================================
module rfp_back
    import rfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_empty,
    input  t_event      i_event,
    output logic        o_pop,
    input  logic        i_res_ready,
    output logic        o_res_valid,
    output logic [1:0]  o_status,
    output logic [7:0]  o_frame_code,
    output logic        o_target_present,
    output logic [7:0]  o_motion_code,
    output logic [15:0] o_distance,
    output logic [7:0]  o_energy
);

    logic        r_valid;
    logic [1:0]  r_status;
    logic [7:0]  r_code;
    logic        r_presence, n_presence;
    logic [7:0]  r_motion,   n_motion;
    logic [15:0] r_distance, n_distance;
    logic [7:0]  r_energy,   n_energy;

    // Latest values change only on a pop, so they double as result fields
    assign o_pop = !i_empty && (!r_valid || i_res_ready);

    always_comb begin
        n_presence = r_presence;
        n_motion   = r_motion;
        n_distance = r_distance;
        n_energy   = r_energy;
        if (i_event.status == ST_OK) begin
            if (i_event.code == i_cfg.code_presence) begin
                n_presence = (i_event.head0 != 8'd0);
            end else if (i_event.code == i_cfg.code_motion) begin
                n_motion = i_event.head0;
            end else if (i_event.code == i_cfg.code_region) begin
                if (i_event.len_ge4) begin
                    n_distance = {i_event.head2, i_event.head1};
                    n_energy   = i_event.head3;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_presence <= 1'b0;
            r_motion   <= 8'd0;
            r_distance <= 16'd0;
            r_energy   <= 8'd0;
        end else begin
            if (o_pop) begin
                r_valid    <= 1'b1;
                r_presence <= n_presence;
                r_motion   <= n_motion;
                r_distance <= n_distance;
                r_energy   <= n_energy;
            end else if (i_res_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status <= i_event.status;
            r_code   <= i_event.code;
        end
    end

    assign o_res_valid      = r_valid;
    assign o_status         = r_status;
    assign o_frame_code     = r_code;
    assign o_target_present = r_presence;
    assign o_motion_code    = r_motion;
    assign o_distance       = r_distance;
    assign o_energy         = r_energy;

    a_pop_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_valid)
        else $error("popped event did not reach the output register");
    a_hold_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_pop |=> $stable(r_presence) && $stable(r_motion)
                   && $stable(r_distance) && $stable(r_energy))
        else $error("latest values changed without an event");
    a_error_no_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_event.status != ST_OK) |=> $stable(r_presence)
        && $stable(r_motion) && $stable(r_distance) && $stable(r_energy))
        else $error("failed frame updated latest values");

endmodule

// ===== src/radar_frame_parser_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// radar_frame_parser_unit: length-prefixed sensor frame parser
// Byte-serial parser: header, 16-bit LE length, code, data, sum8 checksum,
// tail. Reports one status result per finished frame and keeps the latest
// presence, motion, distance and energy values.
// ============================================================================
//
// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+---------------------------
// rx        | in        | i_rx_valid / o_rx_ready   | i_rx_byte
// res       | out       | o_res_valid / i_res_ready | o_status, o_frame_code,
//           |           |                           | o_target_present, ...
// cfg       | in        | i_cfg_we (no wait)        | i_cfg_idx, i_cfg_data
//
// One byte per cycle while the event queue has room: the front end handles each byte as it is taken.
// A frame result passes from the checksum or tail byte through the event queue to the
// output register, which is loaded by the queue-to-back-end pop.
// Reset (synchronous, active low) returns to header hunt with all values zero
// and registers at their defaults.
// The rx side stalls only when the two-entry event queue is full, i.e. when
// results pile up behind a stalled res consumer.
// ============================================================================
module radar_frame_parser_unit
    import rfp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write port
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data,
    // byte input
    input  logic              i_rx_valid,
    output logic              o_rx_ready,
    input  logic [7:0]        i_rx_byte,
    // frame results
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output logic [1:0]        o_status,
    output logic [7:0]        o_frame_code,
    output logic              o_target_present,
    output logic [7:0]        o_motion_code,
    output logic [15:0]       o_distance,
    output logic [7:0]        o_energy
);

    t_cfg   r_cfg;
    logic   w_accept;
    logic   w_push;
    logic   w_pop;
    logic   w_full;
    logic   w_empty;
    t_event w_push_event;
    t_event w_head_event;

    // Configuration registers: decode index, ignore writes beyond the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_value  <= RST_HEADER;
            r_cfg.tail_value    <= RST_TAIL;
            r_cfg.code_presence <= RST_PRESENCE;
            r_cfg.code_motion   <= RST_MOTION;
            r_cfg.code_region   <= RST_REGION;
            r_cfg.length_limit  <= RST_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HEADER:   r_cfg.header_value  <= i_cfg_data[7:0];
                CFG_TAIL:     r_cfg.tail_value    <= i_cfg_data[7:0];
                CFG_PRESENCE: r_cfg.code_presence <= i_cfg_data[7:0];
                CFG_MOTION:   r_cfg.code_motion   <= i_cfg_data[7:0];
                CFG_REGION:   r_cfg.code_region   <= i_cfg_data[7:0];
                CFG_LIMIT:    r_cfg.length_limit  <= i_cfg_data[15:0];
                default:      r_cfg               <= r_cfg;
            endcase
        end
    end

    // Take a byte whenever the queue has room for a possible frame event
    assign o_rx_ready = !w_full;
    assign w_accept   = i_rx_valid && o_rx_ready;

    rfp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_accept (w_accept),
        .i_byte   (i_rx_byte),
        .o_push   (w_push),
        .o_event  (w_push_event)
    );

    rfp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_event  (w_push_event),
        .i_pop    (w_pop),
        .o_event  (w_head_event),
        .o_full   (w_full),
        .o_empty  (w_empty)
    );

    rfp_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_empty          (w_empty),
        .i_event          (w_head_event),
        .o_pop            (w_pop),
        .i_res_ready      (i_res_ready),
        .o_res_valid      (o_res_valid),
        .o_status         (o_status),
        .o_frame_code     (o_frame_code),
        .o_target_present (o_target_present),
        .o_motion_code    (o_motion_code),
        .o_distance       (o_distance),
        .o_energy         (o_energy)
    );

endmodule
